// ----- hdl/hsv2rgb_pkg.sv -----
// Constants and types for the HSV to RGB converter pipeline.
// No dependencies; imported by hsv_to_rgb_converter_top.
package hsv2rgb_pkg;

    // Hue geometry in 1/16 degree units
    localparam logic [9:0]  HUE_SECTOR  = 10'd960;
    // floor(x / 15) = (x * 2185) >> 15 for x < 1024 (x = hue >> 6)
    localparam logic [11:0] DIV15_MUL   = 12'd2185;
    localparam int          DIV15_SHIFT = 15;
    // floor(q / 6) = (q * 43) >> 8 for q < 69
    localparam logic [5:0]  DIV6_MUL    = 6'd43;
    localparam logic [2:0]  SECTOR_CNT  = 3'd6;

    // Fractions: 255 stands for 1.0
    localparam logic [7:0]  FRAC_ONE    = 8'd255;
    // 255 * 960; divided as (x >> 6) / 3825
    localparam logic [17:0] FRAC_DEN    = 18'd244800;
    localparam logic [11:0] DEN_REDUCED = 12'd3825;
    // Reciprocals, rounded down: estimate is the true quotient or one less
    localparam logic [8:0]  DEN_RECIP   = 9'd274;   // floor(2^20 / 3825)
    localparam logic [8:0]  ONE_RECIP   = 9'd257;   // floor(2^16 / 255)

    typedef enum logic [2:0] {
        SECTOR_RED_YEL  = 3'd0,
        SECTOR_YEL_GRN  = 3'd1,
        SECTOR_GRN_CYN  = 3'd2,
        SECTOR_CYN_BLU  = 3'd3,
        SECTOR_BLU_MAG  = 3'd4,
        SECTOR_MAG_RED  = 3'd5
    } sector_t;

endpackage

// ----- hdl/hsv_to_rgb_converter_top.sv -----
// HSV to RGB converter: six-stage pipeline, one pixel per clock while the output drains.
// Depends on hsv2rgb_pkg (constants, sector type).
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------------------
//  input   | in_valid/in_ready   | hue_sixteenths[15:0], saturation[7:0], brightness[7:0]
//  output  | out_valid/out_ready | red[7:0], green[7:0], blue[7:0]
//
// One item enters every cycle while the output drains.
// Stages: hue/960 estimate, sector and remainder, saturation products,
// brightness products, reciprocal quotient estimates, correction and select.
// All stages advance together when the output register is empty or taken;
// a stall freezes the whole pipe, so nothing is lost or repeated.
// Reset (rst_n low) clears only the stage valid bits.
module hsv_to_rgb_converter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] hue_sixteenths,
    input  logic [7:0]  saturation,
    input  logic [7:0]  brightness,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);
    import hsv2rgb_pkg::*;

    logic [5:0]  valid_reg;
    logic        advance;

    // stage 1
    logic [21:0] s1_prod_next;
    logic [15:0] s1_hue_reg;
    logic [7:0]  s1_sat_reg;
    logic [7:0]  s1_bri_reg;
    logic [6:0]  s1_q960_reg;

    // stage 2
    logic [15:0] s2_base;
    logic [11:0] s2_prod6;
    logic [9:0]  s2_res_next;
    logic [9:0]  s2_res_reg;
    logic [6:0]  s2_q960_reg;
    logic [3:0]  s2_div6_reg;
    logic [7:0]  s2_sat_reg;
    logic [7:0]  s2_bri_reg;

    // stage 3
    logic [6:0]  s3_mod_base;
    sector_t     s3_sector_next;
    sector_t     s3_sector_reg;
    logic [17:0] s3_sr_reg;
    logic [17:0] s3_st_reg;
    logic [7:0]  s3_np_reg;
    logic [7:0]  s3_bri_reg;

    // stage 4
    logic [25:0] s4_pq_reg;
    logic [25:0] s4_pt_reg;
    logic [15:0] s4_pp_reg;
    logic [7:0]  s4_bri_reg;
    sector_t     s4_sector_reg;

    // stage 5
    logic [28:0] s5_prodq;
    logic [28:0] s5_prodt;
    logic [24:0] s5_prodp;
    logic [19:0] s5_yq_reg;
    logic [19:0] s5_yt_reg;
    logic [15:0] s5_pp_reg;
    logic [7:0]  s5_q0q_reg;
    logic [7:0]  s5_q0t_reg;
    logic [7:0]  s5_q0p_reg;
    logic [7:0]  s5_bri_reg;
    sector_t     s5_sector_reg;

    // stage 6
    logic [19:0] s6_remq;
    logic [19:0] s6_remt;
    logic [15:0] s6_remp;
    logic [7:0]  s6_lq;
    logic [7:0]  s6_lt;
    logic [7:0]  s6_lp;
    logic [7:0]  red_next;
    logic [7:0]  green_next;
    logic [7:0]  blue_next;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;

    assign advance   = !valid_reg[5] || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg[5];
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    // hue / 960 = (hue >> 6) / 15
    assign s1_prod_next = 22'(hue_sixteenths[15:6]) * 22'(DIV15_MUL);

    // remainder within sector, and (hue / 960) / 6 for the wrap to 0..5
    assign s2_base     = 16'(s1_q960_reg) * 16'(HUE_SECTOR);
    assign s2_res_next = 10'(s1_hue_reg - s2_base);
    assign s2_prod6    = 12'(s1_q960_reg) * 12'(DIV6_MUL);

    assign s3_mod_base    = 7'(s2_div6_reg) * 7'(SECTOR_CNT);
    assign s3_sector_next = sector_t'(3'(s2_q960_reg - s3_mod_base));

    // quotient estimates; each may be one short
    assign s5_prodq = 29'(s4_pq_reg[25:6]) * 29'(DEN_RECIP);
    assign s5_prodt = 29'(s4_pt_reg[25:6]) * 29'(DEN_RECIP);
    assign s5_prodp = 25'(s4_pp_reg) * 25'(ONE_RECIP);

    // single correction step
    assign s6_remq = s5_yq_reg - 20'(s5_q0q_reg) * 20'(DEN_REDUCED);
    assign s6_remt = s5_yt_reg - 20'(s5_q0t_reg) * 20'(DEN_REDUCED);
    assign s6_remp = s5_pp_reg - 16'(s5_q0p_reg) * 16'(FRAC_ONE);
    assign s6_lq   = (s6_remq >= 20'(DEN_REDUCED)) ? s5_q0q_reg + 8'd1 : s5_q0q_reg;
    assign s6_lt   = (s6_remt >= 20'(DEN_REDUCED)) ? s5_q0t_reg + 8'd1 : s5_q0t_reg;
    assign s6_lp   = (s6_remp >= 16'(FRAC_ONE))    ? s5_q0p_reg + 8'd1 : s5_q0p_reg;

    always_comb
    begin
        unique case (s5_sector_reg)
            SECTOR_RED_YEL:
            begin
                red_next = s5_bri_reg; green_next = s6_lt; blue_next = s6_lp;
            end
            SECTOR_YEL_GRN:
            begin
                red_next = s6_lq; green_next = s5_bri_reg; blue_next = s6_lp;
            end
            SECTOR_GRN_CYN:
            begin
                red_next = s6_lp; green_next = s5_bri_reg; blue_next = s6_lt;
            end
            SECTOR_CYN_BLU:
            begin
                red_next = s6_lp; green_next = s6_lq; blue_next = s5_bri_reg;
            end
            SECTOR_BLU_MAG:
            begin
                red_next = s6_lt; green_next = s6_lp; blue_next = s5_bri_reg;
            end
            default:
            begin
                red_next = s5_bri_reg; green_next = s6_lp; blue_next = s6_lq;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_hue_reg    <= hue_sixteenths;
            s1_sat_reg    <= saturation;
            s1_bri_reg    <= brightness;
            s1_q960_reg   <= s1_prod_next[DIV15_SHIFT+6:DIV15_SHIFT];

            s2_res_reg    <= s2_res_next;
            s2_q960_reg   <= s1_q960_reg;
            s2_div6_reg   <= s2_prod6[11:8];
            s2_sat_reg    <= s1_sat_reg;
            s2_bri_reg    <= s1_bri_reg;

            s3_sector_reg <= s3_sector_next;
            s3_sr_reg     <= 18'(s2_sat_reg) * 18'(s2_res_reg);
            s3_st_reg     <= 18'(s2_sat_reg) * (18'(HUE_SECTOR) - 18'(s2_res_reg));
            s3_np_reg     <= FRAC_ONE - s2_sat_reg;
            s3_bri_reg    <= s2_bri_reg;

            s4_pq_reg     <= 26'(s3_bri_reg) * 26'(FRAC_DEN - s3_sr_reg);
            s4_pt_reg     <= 26'(s3_bri_reg) * 26'(FRAC_DEN - s3_st_reg);
            s4_pp_reg     <= 16'(s3_bri_reg) * 16'(s3_np_reg);
            s4_bri_reg    <= s3_bri_reg;
            s4_sector_reg <= s3_sector_reg;

            s5_yq_reg     <= s4_pq_reg[25:6];
            s5_yt_reg     <= s4_pt_reg[25:6];
            s5_pp_reg     <= s4_pp_reg;
            s5_q0q_reg    <= s5_prodq[27:20];
            s5_q0t_reg    <= s5_prodt[27:20];
            s5_q0p_reg    <= s5_prodp[23:16];
            s5_bri_reg    <= s4_bri_reg;
            s5_sector_reg <= s4_sector_reg;

            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
        end
    end

endmodule
